FILE: hdl/scrf_pkg.sv
`timescale 1ns / 1ps

package scrf_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned REGION_COUNT = 8;

  localparam logic [31:0] CTRL_WRITE_MASK = 32'h000F_F085;
  localparam logic [31:0] CTRL_RESET      = 32'h0000_2078;
  localparam logic [31:0] ID_RESET        = 32'h4105_9461;
  localparam logic [31:0] CTYPE_RESET     = 32'h0F0D_2112;
  localparam logic [31:0] TCMSZ_RESET     = 32'h0014_0180;

  localparam int unsigned HIVEC_BIT = 13;

  typedef enum logic [1:0] {
    CFG_IDENTITY   = 2'd0,
    CFG_CACHE_TYPE = 2'd1,
    CFG_TCM_SIZE   = 2'd2
  } cfg_idx_t;

  localparam logic [3:0] PR_REGION = 4'd6;

  // {primary, secondary, opcode2}
  localparam logic [10:0] ADDR_ID     = {4'd0, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_CTYPE  = {4'd0, 4'd0, 3'd1};
  localparam logic [10:0] ADDR_TCMSZ  = {4'd0, 4'd0, 3'd2};
  localparam logic [10:0] ADDR_CTRL   = {4'd1, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_DCACHE = {4'd2, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_ICACHE = {4'd2, 4'd0, 3'd1};
  localparam logic [10:0] ADDR_WBUF   = {4'd3, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_DAP    = {4'd5, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_IAP    = {4'd5, 4'd0, 3'd1};
  localparam logic [10:0] ADDR_DAPX   = {4'd5, 4'd0, 3'd2};
  localparam logic [10:0] ADDR_IAPX   = {4'd5, 4'd0, 3'd3};
  localparam logic [10:0] ADDR_DLOCK  = {4'd9, 4'd0, 3'd0};
  localparam logic [10:0] ADDR_ILOCK  = {4'd9, 4'd0, 3'd1};
  localparam logic [10:0] ADDR_DTCM   = {4'd9, 4'd1, 3'd0};
  localparam logic [10:0] ADDR_ITCM   = {4'd9, 4'd1, 3'd1};

  localparam logic [2:0] OP_REGION_D = 3'd0;
  localparam logic [2:0] OP_REGION_I = 3'd1;

  typedef enum logic [4:0] {
    SEL_NONE,
    SEL_ID,
    SEL_CTYPE,
    SEL_TCMSZ,
    SEL_CTRL,
    SEL_DCACHE,
    SEL_ICACHE,
    SEL_WBUF,
    SEL_DAP,
    SEL_IAP,
    SEL_DAPX,
    SEL_IAPX,
    SEL_DREG,
    SEL_IREG,
    SEL_DLOCK,
    SEL_ILOCK,
    SEL_DTCM,
    SEL_ITCM
  } reg_sel_t;

  typedef struct packed {
    logic        vld;
    logic        wr;
    reg_sel_t    sel;
    logic [3:0]  region;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0] identity;
    logic [31:0] cache_type;
    logic [31:0] tcm_size;
  } id_words_t;

endpackage

FILE: hdl/scrf_dec.sv
`timescale 1ns / 1ps

module scrf_dec #(
  parameter int unsigned REGION_COUNT = scrf_pkg::REGION_COUNT
) (
  input  logic [3:0]         primary_reg,
  input  logic [3:0]         secondary_reg,
  input  logic [2:0]         opcode_two,
  output scrf_pkg::reg_sel_t sel
);

  logic [10:0] key;
  logic        region_ok;

  assign key       = {primary_reg, secondary_reg, opcode_two};
  assign region_ok = {1'b0, secondary_reg} < 5'(REGION_COUNT);

  always_comb begin
    sel = scrf_pkg::SEL_NONE;
    if (primary_reg == scrf_pkg::PR_REGION) begin
      if (region_ok && opcode_two == scrf_pkg::OP_REGION_D) begin
        sel = scrf_pkg::SEL_DREG;
      end else if (region_ok && opcode_two == scrf_pkg::OP_REGION_I) begin
        sel = scrf_pkg::SEL_IREG;
      end
    end else begin
      unique case (key)
        scrf_pkg::ADDR_ID:     sel = scrf_pkg::SEL_ID;
        scrf_pkg::ADDR_CTYPE:  sel = scrf_pkg::SEL_CTYPE;
        scrf_pkg::ADDR_TCMSZ:  sel = scrf_pkg::SEL_TCMSZ;
        scrf_pkg::ADDR_CTRL:   sel = scrf_pkg::SEL_CTRL;
        scrf_pkg::ADDR_DCACHE: sel = scrf_pkg::SEL_DCACHE;
        scrf_pkg::ADDR_ICACHE: sel = scrf_pkg::SEL_ICACHE;
        scrf_pkg::ADDR_WBUF:   sel = scrf_pkg::SEL_WBUF;
        scrf_pkg::ADDR_DAP:    sel = scrf_pkg::SEL_DAP;
        scrf_pkg::ADDR_IAP:    sel = scrf_pkg::SEL_IAP;
        scrf_pkg::ADDR_DAPX:   sel = scrf_pkg::SEL_DAPX;
        scrf_pkg::ADDR_IAPX:   sel = scrf_pkg::SEL_IAPX;
        scrf_pkg::ADDR_DLOCK:  sel = scrf_pkg::SEL_DLOCK;
        scrf_pkg::ADDR_ILOCK:  sel = scrf_pkg::SEL_ILOCK;
        scrf_pkg::ADDR_DTCM:   sel = scrf_pkg::SEL_DTCM;
        scrf_pkg::ADDR_ITCM:   sel = scrf_pkg::SEL_ITCM;
        default:               sel = scrf_pkg::SEL_NONE;
      endcase
    end
  end

endmodule

FILE: hdl/scrf_regs.sv
`timescale 1ns / 1ps

module scrf_regs #(
  parameter int unsigned REGION_COUNT = scrf_pkg::REGION_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scrf_pkg::access_t   acc,
  input  scrf_pkg::id_words_t ids,
  output logic [31:0]         read_data,
  output logic                address_known,
  output logic                high_vectors
);

  localparam int unsigned RIDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] dcache_r, icache_r, wbuf_r;
  logic [31:0] dap_r, iap_r, dapx_r, iapx_r;
  logic [31:0] dlock_r, ilock_r, dtcm_r, itcm_r;
  logic [31:0] dreg_r [REGION_COUNT];
  logic [31:0] ireg_r [REGION_COUNT];

  logic [RIDX_W-1:0] ridx;
  logic              is_id;
  logic              wr_en;
  logic [31:0]       slot_data;

  assign ridx  = acc.region[RIDX_W-1:0];
  assign is_id = (acc.sel == scrf_pkg::SEL_ID) || (acc.sel == scrf_pkg::SEL_CTYPE) ||
                 (acc.sel == scrf_pkg::SEL_TCMSZ);
  assign wr_en = acc.vld && acc.wr && !is_id && (acc.sel != scrf_pkg::SEL_NONE);

  always_comb begin
    ctrl_nxt = ctrl_r;
    if (wr_en && acc.sel == scrf_pkg::SEL_CTRL) begin
      ctrl_nxt = (ctrl_r & ~scrf_pkg::CTRL_WRITE_MASK) |
                 (acc.wdata & scrf_pkg::CTRL_WRITE_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= scrf_pkg::CTRL_RESET;
      dcache_r <= '0;
      icache_r <= '0;
      wbuf_r   <= '0;
      dap_r    <= '0;
      iap_r    <= '0;
      dapx_r   <= '0;
      iapx_r   <= '0;
      dlock_r  <= '0;
      ilock_r  <= '0;
      dtcm_r   <= '0;
      itcm_r   <= '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        dreg_r[i] <= '0;
        ireg_r[i] <= '0;
      end
    end else begin
      ctrl_r <= ctrl_nxt;
      if (wr_en) begin
        case (acc.sel)
          scrf_pkg::SEL_DCACHE: dcache_r     <= acc.wdata;
          scrf_pkg::SEL_ICACHE: icache_r     <= acc.wdata;
          scrf_pkg::SEL_WBUF:   wbuf_r       <= acc.wdata;
          scrf_pkg::SEL_DAP:    dap_r        <= acc.wdata;
          scrf_pkg::SEL_IAP:    iap_r        <= acc.wdata;
          scrf_pkg::SEL_DAPX:   dapx_r       <= acc.wdata;
          scrf_pkg::SEL_IAPX:   iapx_r       <= acc.wdata;
          scrf_pkg::SEL_DLOCK:  dlock_r      <= acc.wdata;
          scrf_pkg::SEL_ILOCK:  ilock_r      <= acc.wdata;
          scrf_pkg::SEL_DTCM:   dtcm_r       <= acc.wdata;
          scrf_pkg::SEL_ITCM:   itcm_r       <= acc.wdata;
          scrf_pkg::SEL_DREG:   dreg_r[ridx] <= acc.wdata;
          scrf_pkg::SEL_IREG:   ireg_r[ridx] <= acc.wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (acc.sel)
      scrf_pkg::SEL_ID:     slot_data = ids.identity;
      scrf_pkg::SEL_CTYPE:  slot_data = ids.cache_type;
      scrf_pkg::SEL_TCMSZ:  slot_data = ids.tcm_size;
      scrf_pkg::SEL_CTRL:   slot_data = ctrl_r;
      scrf_pkg::SEL_DCACHE: slot_data = dcache_r;
      scrf_pkg::SEL_ICACHE: slot_data = icache_r;
      scrf_pkg::SEL_WBUF:   slot_data = wbuf_r;
      scrf_pkg::SEL_DAP:    slot_data = dap_r;
      scrf_pkg::SEL_IAP:    slot_data = iap_r;
      scrf_pkg::SEL_DAPX:   slot_data = dapx_r;
      scrf_pkg::SEL_IAPX:   slot_data = iapx_r;
      scrf_pkg::SEL_DLOCK:  slot_data = dlock_r;
      scrf_pkg::SEL_ILOCK:  slot_data = ilock_r;
      scrf_pkg::SEL_DTCM:   slot_data = dtcm_r;
      scrf_pkg::SEL_ITCM:   slot_data = itcm_r;
      scrf_pkg::SEL_DREG:   slot_data = dreg_r[ridx];
      scrf_pkg::SEL_IREG:   slot_data = ireg_r[ridx];
      default:              slot_data = '0;
    endcase
  end

  assign read_data     = acc.wr ? '0 : slot_data;
  assign address_known = acc.wr ? !is_id && (acc.sel != scrf_pkg::SEL_NONE)
                                : (acc.sel != scrf_pkg::SEL_NONE);
  assign high_vectors  = ctrl_nxt[scrf_pkg::HIVEC_BIT];

endmodule

FILE: hdl/system_coprocessor_register_file.sv
`timescale 1ns / 1ps

// out_valid and the result pass through the input register, then the result register.
// Throughput: one item per cycle; busy is held low, each access finishes in a single pass.
// Reset (rst_n, synchronous): control word 0x00002078, other coprocessor registers and the
// valid flags zero, ID words to defaults; input and result data registers are not reset.
// The receiver cannot stall; each result stands on the out_ ports for one cycle.
module system_coprocessor_register_file #(
  parameter int unsigned REGION_COUNT = scrf_pkg::REGION_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [3:0]  in_primary_reg,
  input  logic [3:0]  in_secondary_reg,
  input  logic [2:0]  in_opcode_two,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_address_known,
  output logic        out_high_vectors,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic        vld_r;
  logic        cmd_r;
  logic [3:0]  pr_r, sr_r;
  logic [2:0]  op_r;
  logic [31:0] wd_r;

  scrf_pkg::id_words_t ids_r;
  scrf_pkg::reg_sel_t  sel;
  scrf_pkg::access_t   acc;

  logic [31:0] rd;
  logic        known;
  logic        hv;

  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic        out_address_known_r;
  logic        out_high_vectors_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_command;
      pr_r  <= in_primary_reg;
      sr_r  <= in_secondary_reg;
      op_r  <= in_opcode_two;
      wd_r  <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r.identity   <= scrf_pkg::ID_RESET;
      ids_r.cache_type <= scrf_pkg::CTYPE_RESET;
      ids_r.tcm_size   <= scrf_pkg::TCMSZ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scrf_pkg::CFG_IDENTITY:   ids_r.identity   <= cfg_wdata;
        scrf_pkg::CFG_CACHE_TYPE: ids_r.cache_type <= cfg_wdata;
        scrf_pkg::CFG_TCM_SIZE:   ids_r.tcm_size   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scrf_dec #(
    .REGION_COUNT(REGION_COUNT)
  ) u_dec (
    .primary_reg  (pr_r),
    .secondary_reg(sr_r),
    .opcode_two   (op_r),
    .sel          (sel)
  );

  assign acc.vld    = vld_r;
  assign acc.wr     = cmd_r;
  assign acc.sel    = sel;
  assign acc.region = sr_r;
  assign acc.wdata  = wd_r;

  scrf_regs #(
    .REGION_COUNT(REGION_COUNT)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .ids          (ids_r),
    .read_data    (rd),
    .address_known(known),
    .high_vectors (hv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      out_read_data_r     <= rd;
      out_address_known_r <= known;
      out_high_vectors_r  <= hv;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_address_known = out_address_known_r;
  assign out_high_vectors  = out_high_vectors_r;

  a_strobe_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("item accepted without a result two cycles later");

  a_unknown_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_address_known) |-> (out_read_data == '0))
    else $error("unknown address returned nonzero data");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && cmd_r) |=> (out_valid && out_read_data == '0))
    else $error("write access returned nonzero data");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r |=> !out_valid)
    else $error("result strobe without an item");

endmodule

FILE: tb/cp15_tb_pkg.sv
`timescale 1ns / 1ps

package cp15_tb_pkg;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cp15_cmd_t;

endpackage

FILE: tb/cp15_checker.sv
`timescale 1ns / 1ps

module cp15_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_command,
  input  logic [3:0]  in_primary_reg,
  input  logic [3:0]  in_secondary_reg,
  input  logic [2:0]  in_opcode_two,
  input  logic [31:0] in_write_data,
  input  logic        out_valid,
  input  logic [31:0] out_read_data,
  input  logic        out_address_known,
  input  logic        out_high_vectors,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);

  import scrf_pkg::*;
  import cp15_tb_pkg::*;

  typedef struct packed {
    logic [31:0] read_data;
    logic        known;
    logic        hivec;
  } cp15_result_t;

  cp15_result_t expected_q[$];
  cp15_result_t want;
  cp15_result_t access_result;
  logic [31:0]  id_words [0:2];
  logic [31:0]  shadow   [0:2047];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic is_writable(input logic [10:0] a);
    if (a[10:7] == PR_REGION) begin
      return (a[6:3] < REGION_COUNT) && (a[2:0] == OP_REGION_D || a[2:0] == OP_REGION_I);
    end
    case (a)
      ADDR_CTRL, ADDR_DCACHE, ADDR_ICACHE, ADDR_WBUF, ADDR_DAP, ADDR_IAP, ADDR_DAPX,
      ADDR_IAPX, ADDR_DLOCK, ADDR_ILOCK, ADDR_DTCM, ADDR_ITCM: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < 2048; i++) shadow[i] = '0;
    shadow[ADDR_CTRL] = CTRL_RESET;
    id_words[0] = ID_RESET;
    id_words[1] = CTYPE_RESET;
    id_words[2] = TCMSZ_RESET;
    expected_q.delete();
  endtask

  task automatic cp15_access(input logic wr, input logic [10:0] a, input logic [31:0] wd,
                             output cp15_result_t r);
    r = '0;
    if (wr == CMD_WRITE) begin
      if (is_writable(a)) begin
        if (a == ADDR_CTRL) begin
          shadow[a] = (shadow[a] & ~CTRL_WRITE_MASK) | (wd & CTRL_WRITE_MASK);
        end else begin
          shadow[a] = wd;
        end
        r.known = 1'b1;
      end
    end else if (a == ADDR_ID || a == ADDR_CTYPE || a == ADDR_TCMSZ) begin
      r.read_data = id_words[a[1:0]];
      r.known     = 1'b1;
    end else if (is_writable(a)) begin
      r.read_data = shadow[a];
      r.known     = 1'b1;
    end
    r.hivec = shadow[ADDR_CTRL][HIVEC_BIT];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    $display("[%0t] %s: got %h, expected %h", $time, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_shadow();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no access outstanding", out_read_data, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_address_known !== want.known)
            report_mismatch("address_known", 32'(out_address_known), 32'(want.known));
          if (out_high_vectors !== want.hivec)
            report_mismatch("high_vectors", 32'(out_high_vectors), 32'(want.hivec));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDENTITY:   id_words[0] = cfg_wdata;
          CFG_CACHE_TYPE: id_words[1] = cfg_wdata;
          CFG_TCM_SIZE:   id_words[2] = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        cp15_access(in_command, {in_primary_reg, in_secondary_reg, in_opcode_two},
                    in_write_data, access_result);
        expected_q.push_back(access_result);
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import scrf_pkg::*;
  import cp15_tb_pkg::*;

  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_ITEMS = 450;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [3:0]  in_primary_reg;
  logic [3:0]  in_secondary_reg;
  logic [2:0]  in_opcode_two;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic        out_address_known;
  logic        out_high_vectors;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int          errors;
  int          pending;
  int          idle_pct;
  int          cycle_count = 0;

  logic [10:0] known_addrs [15] = '{ADDR_ID, ADDR_CTYPE, ADDR_TCMSZ, ADDR_CTRL, ADDR_DCACHE,
                                    ADDR_ICACHE, ADDR_WBUF, ADDR_DAP, ADDR_IAP, ADDR_DAPX,
                                    ADDR_IAPX, ADDR_DLOCK, ADDR_ILOCK, ADDR_DTCM, ADDR_ITCM};

  always #4 clk = ~clk;

  system_coprocessor_register_file u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_primary_reg(in_primary_reg),
    .in_secondary_reg(in_secondary_reg), .in_opcode_two(in_opcode_two),
    .in_write_data(in_write_data), .out_valid(out_valid), .out_read_data(out_read_data),
    .out_address_known(out_address_known), .out_high_vectors(out_high_vectors),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cp15_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_primary_reg(in_primary_reg),
    .in_secondary_reg(in_secondary_reg), .in_opcode_two(in_opcode_two),
    .in_write_data(in_write_data), .out_valid(out_valid), .out_read_data(out_read_data),
    .out_address_known(out_address_known), .out_high_vectors(out_high_vectors),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue(input cp15_cmd_t cmd, input logic [10:0] a, input logic [31:0] wd);
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start            <= 1'b1;
    in_command       <= cmd;
    in_primary_reg   <= a[10:7];
    in_secondary_reg <= a[6:3];
    in_opcode_two    <= a[2:0];
    in_write_data    <= wd;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_access();
    logic [10:0] a;
    logic [31:0] wd;
    cp15_cmd_t   cmd;
    cmd = cp15_cmd_t'($urandom_range(1));
    case ($urandom_range(9))
      0, 1:    a = 11'($urandom);
      2, 3:    a = {PR_REGION, 4'($urandom_range(REGION_COUNT - 1)),
                    $urandom_range(1) ? OP_REGION_I : OP_REGION_D};
      default: a = known_addrs[$urandom_range(14)];
    endcase
    case ($urandom_range(7))
      0:       wd = '0;
      1:       wd = '1;
      default: wd = $urandom;
    endcase
    issue(cmd, a, wd);
  endtask

  // Lets every outstanding access come back before anything else happens.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_ids(input logic [31:0] id, input logic [31:0] ctype,
                             input logic [31:0] tcm);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDENTITY;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_index <= CFG_CACHE_TYPE;
    cfg_wdata <= ctype;
    @(negedge clk);
    cfg_index <= CFG_TCM_SIZE;
    cfg_wdata <= tcm;
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= $urandom;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_READ;
    in_primary_reg   = '0;
    in_secondary_reg = '0;
    in_opcode_two    = '0;
    in_write_data    = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_IDENTITY;
    cfg_wdata        = '0;
    idle_pct         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ID words at reset, then all ones, then writes and reads of known and unknown addresses
    issue(CMD_READ,  ADDR_ID,    '0);
    issue(CMD_READ,  ADDR_CTYPE, '0);
    issue(CMD_READ,  ADDR_TCMSZ, '0);
    settle();
    program_ids('1, '1, '1);
    issue(CMD_READ,  ADDR_ID,    '0);
    issue(CMD_READ,  ADDR_TCMSZ, '0);
    issue(CMD_WRITE, ADDR_ID,    32'h1234_5678);
    issue(CMD_READ,  ADDR_ID,    '0);
    issue(CMD_READ,  {4'd0, 4'd0, 3'd3}, '0);
    issue(CMD_WRITE, ADDR_CTRL,  '1);
    issue(CMD_READ,  ADDR_CTRL,  '0);
    issue(CMD_WRITE, ADDR_CTRL,  '0);
    issue(CMD_READ,  ADDR_CTRL,  '1);
    issue(CMD_WRITE, {PR_REGION, 4'd7, OP_REGION_D}, '1);
    issue(CMD_READ,  {PR_REGION, 4'd7, OP_REGION_D}, '0);
    issue(CMD_WRITE, {PR_REGION, 4'd0, OP_REGION_I}, 32'hA5A5_5A5A);
    issue(CMD_READ,  {PR_REGION, 4'd0, OP_REGION_I}, '0);
    issue(CMD_WRITE, {PR_REGION, 4'd8, OP_REGION_D}, '1);
    issue(CMD_READ,  {PR_REGION, 4'd15, OP_REGION_I}, '0);
    issue(CMD_WRITE, {PR_REGION, 4'd0, 3'd2}, '1);
    issue(CMD_WRITE, ADDR_ITCM,  32'h5A5A_A5A5);
    issue(CMD_READ,  ADDR_ITCM,  '0);
    issue(CMD_WRITE, {4'd15, 4'd15, 3'd7}, '1);
    issue(CMD_READ,  {4'd15, 4'd15, 3'd7}, '0);
    issue(CMD_WRITE, ADDR_IAPX,  '1);
    issue(CMD_READ,  ADDR_IAPX,  '0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: program_ids('0, '0, '0);
        2: program_ids(ID_RESET, CTYPE_RESET, TCMSZ_RESET);
        default: program_ids($urandom, $urandom, $urandom);
      endcase
      case (phase)
        1:       idle_pct = 47;
        2:       idle_pct = 31;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // last phase alternates idle stretches with back-to-back ones
        if (phase == 3 && n % 50 == 0) idle_pct = (n % 100 == 0) ? 47 : 0;
        random_access();
      end
      settle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
